// ===== hdl/ets_pkg.sv =====
// Package for the exhaustive tour search block: request payload types and widths.
// No dependencies.
package ets_pkg;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned LEN_W   = 20;
    localparam int unsigned IDX_W   = 3;
    localparam logic [LEN_W-1:0] LEN_MAX = 20'hFFFFF;
    localparam logic [LEN_W-1:0] LIMIT_RESET = 20'd256000;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      last_point;
    } in_req_t;

    typedef struct packed {
        logic [IDX_W-1:0] tour_index;
        logic [LEN_W-1:0] tour_length;
        logic             found;
        logic             last_result;
    } out_req_t;

endpackage

// ===== hdl/ets_isqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
// Depends on nothing outside this file.
module ets_isqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [33:0] radicand,
    output logic        done,
    output logic [16:0] root
);
    localparam int unsigned STEPS = 17;

    logic [33:0] rem_reg, rem_next;
    logic [16:0] res_reg, res_next;
    logic [33:0] val_reg, val_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [35:0] trial;
    logic [35:0] shifted;

    always_comb begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        val_next  = val_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, val_reg[33:32]};
        trial     = {17'd0, res_reg, 2'b01};
        if (start) begin
            rem_next  = '0;
            res_next  = '0;
            val_next  = radicand;
            cnt_next  = 5'(STEPS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            val_next = {val_reg[31:0], 2'b00};
            if (shifted >= trial) begin
                rem_next = 34'(shifted - trial);
                res_next = {res_reg[15:0], 1'b1};
            end else begin
                rem_next = shifted[33:0];
                res_next = {res_reg[15:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        val_reg <= val_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign root = res_reg;
endmodule

// ===== hdl/exhaustive_tour_search.sv =====
// Exhaustive tour search. Points load one per cycle; the request flagged last
// starts a search over all n! orderings of the stored points. Each tour edge
// takes a difference step, two passes through the shared squarer, a root start
// and a wait on the 17-step square root unit; s_ready is low throughout the
// search. Results then drain at one per cycle while m_ready is high, n+1
// requests (or one when no tour beats the configured limit).
module exhaustive_tour_search #(
    parameter int unsigned MAX_POINTS = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  ets_pkg::in_req_t       s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output ets_pkg::out_req_t      m_data,
    input  logic                   cfg_we,
    input  logic [ets_pkg::LEN_W-1:0] cfg_data
);
    localparam int unsigned PW = $clog2(MAX_POINTS);
    localparam int unsigned CW = $clog2(MAX_POINTS + 1);

    localparam logic [3:0] ST_LOAD  = 4'd0;
    localparam logic [3:0] ST_EDGE  = 4'd1;
    localparam logic [3:0] ST_SQ    = 4'd2;
    localparam logic [3:0] ST_ROOT  = 4'd3;
    localparam logic [3:0] ST_WAIT  = 4'd4;
    localparam logic [3:0] ST_CMP   = 4'd5;
    localparam logic [3:0] ST_FINDI = 4'd6;
    localparam logic [3:0] ST_FINDJ = 4'd7;
    localparam logic [3:0] ST_REV   = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;
    localparam logic [3:0] ST_SQY   = 4'd10;

    logic [3:0] state_reg, state_next;

    logic signed [15:0] xs_reg [MAX_POINTS];
    logic signed [15:0] ys_reg [MAX_POINTS];
    logic [PW-1:0] cur_reg  [MAX_POINTS];
    logic [PW-1:0] cur_next [MAX_POINTS];
    logic [PW-1:0] best_reg [MAX_POINTS];
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [ets_pkg::LEN_W-1:0] limit_reg, best_len_reg, best_len_next;
    logic [ets_pkg::LEN_W-1:0] run_reg, run_next;
    logic found_reg, found_next;
    logic [PW-1:0] ei_reg, ei_next;
    logic [PW-1:0] i_reg, i_next, j_reg, j_next;
    logic [CW-1:0] oi_reg, oi_next;
    logic signed [16:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [33:0] sq_reg, sq_next;
    logic signed [16:0] sq_op;
    logic signed [33:0] sq_full;
    logic [33:0] prod;
    logic        best_wr;
    logic        sq_start, sq_done;
    logic [16:0] sq_root;
    logic [20:0] sum;
    logic [PW-1:0] a_idx, b_idx, last_idx;

    ets_isqrt u_isqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sq_start), .radicand(sq_reg),
        .done(sq_done), .root(sq_root)
    );

    assign last_idx = PW'(cnt_reg - CW'(1));
    assign a_idx = cur_reg[ei_reg];
    assign b_idx = (ei_reg == last_idx) ? cur_reg[0] : cur_reg[PW'(ei_reg + PW'(1))];
    // one shared 17x17 squarer, used for dx then dy
    assign sq_op   = (state_reg == ST_SQ) ? dx_reg : dy_reg;
    assign sq_full = sq_op * sq_op;
    assign prod    = $unsigned(sq_full);
    assign sum = {1'b0, run_reg} + {4'd0, sq_root};

    always_comb begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        cnt_next      = cnt_reg;
        best_len_next = best_len_reg;
        run_next      = run_reg;
        found_next    = found_reg;
        ei_next       = ei_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        oi_next       = oi_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        sq_next       = sq_reg;
        sq_start      = 1'b0;
        best_wr       = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_valid) begin
                    if (cnt_reg < CW'(MAX_POINTS)) cnt_next = cnt_reg + CW'(1);
                    if (s_data.last_point) begin
                        state_next    = ST_EDGE;
                        best_len_next = limit_reg;
                        found_next    = 1'b0;
                        run_next      = '0;
                        ei_next       = '0;
                        for (int k = 0; k < MAX_POINTS; k++) cur_next[k] = PW'(k);
                    end
                end
            end
            ST_EDGE: begin
                dx_next = 17'(xs_reg[b_idx]) - 17'(xs_reg[a_idx]);
                dy_next = 17'(ys_reg[b_idx]) - 17'(ys_reg[a_idx]);
                state_next = ST_SQ;
            end
            ST_SQ: begin
                sq_next = prod;
                state_next = ST_SQY;
            end
            ST_SQY: begin
                sq_next = sq_reg + prod;
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                sq_start = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (sq_done) begin
                    run_next = sum > 21'(ets_pkg::LEN_MAX) ? ets_pkg::LEN_MAX : sum[19:0];
                    if (ei_reg == last_idx) state_next = ST_CMP;
                    else begin
                        ei_next = ei_reg + PW'(1);
                        state_next = ST_EDGE;
                    end
                end
            end
            ST_CMP: begin
                if (run_reg < best_len_reg) begin
                    best_len_next = run_reg;
                    best_wr = 1'b1;
                    found_next = 1'b1;
                end
                i_next = last_idx;
                state_next = (cnt_reg < CW'(2)) ? ST_OUT : ST_FINDI;
                oi_next = '0;
            end
            ST_FINDI: begin
                if (i_reg == '0) begin
                    state_next = ST_OUT;
                end else if (cur_reg[PW'(i_reg - PW'(1))] < cur_reg[i_reg]) begin
                    j_next = last_idx;
                    state_next = ST_FINDJ;
                end else begin
                    i_next = i_reg - PW'(1);
                end
            end
            ST_FINDJ: begin
                if (cur_reg[j_reg] > cur_reg[PW'(i_reg - PW'(1))]) begin
                    cur_next[j_reg] = cur_reg[PW'(i_reg - PW'(1))];
                    cur_next[PW'(i_reg - PW'(1))] = cur_reg[j_reg];
                    j_next = last_idx;
                    state_next = ST_REV;
                end else begin
                    j_next = j_reg - PW'(1);
                end
            end
            ST_REV: begin
                if (i_reg < j_reg) begin
                    cur_next[i_reg] = cur_reg[j_reg];
                    cur_next[j_reg] = cur_reg[i_reg];
                    i_next = i_reg + PW'(1);
                    j_next = j_reg - PW'(1);
                end else begin
                    run_next = '0;
                    ei_next = '0;
                    state_next = ST_EDGE;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    if (!found_reg || oi_reg == cnt_reg) begin
                        state_next = ST_LOAD;
                        cnt_next = '0;
                        run_next = '0;
                        best_len_next = limit_reg;
                        for (int k = 0; k < MAX_POINTS; k++) cur_next[k] = PW'(k);
                    end else begin
                        oi_next = oi_reg + CW'(1);
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
        if (cfg_we) best_len_next = cfg_data;
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOAD && s_valid && cnt_reg < CW'(MAX_POINTS)) begin
            xs_reg[PW'(cnt_reg)] <= s_data.point_x;
            ys_reg[PW'(cnt_reg)] <= s_data.point_y;
        end
        if (best_wr) best_reg <= cur_reg;
        ei_reg <= ei_next;
        i_reg  <= i_next;
        j_reg  <= j_next;
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        sq_reg <= sq_next;
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            cnt_reg      <= '0;
            limit_reg    <= ets_pkg::LIMIT_RESET;
            best_len_reg <= ets_pkg::LIMIT_RESET;
            run_reg      <= '0;
            found_reg    <= 1'b0;
            oi_reg       <= '0;
            for (int k = 0; k < MAX_POINTS; k++) cur_reg[k] <= PW'(k);
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            if (cfg_we) limit_reg <= cfg_data;
            best_len_reg <= best_len_next;
            run_reg      <= run_next;
            found_reg    <= found_next;
            oi_reg       <= oi_next;
            cur_reg      <= cur_next;
        end
    end

    logic [PW-1:0] out_pos;
    logic [PW-1:0] out_sel;
    assign out_pos = (oi_reg == cnt_reg) ? '0 : PW'(oi_reg);
    assign out_sel = best_reg[out_pos];

    assign s_ready = (state_reg == ST_LOAD);
    assign m_valid = (state_reg == ST_OUT);
    always_comb begin
        m_data.tour_index  = found_reg ? 3'(out_sel) : '0;
        m_data.tour_length = found_reg ? best_len_reg : '0;
        m_data.found       = found_reg;
        m_data.last_result = !found_reg || (oi_reg == cnt_reg);
    end
endmodule

// ===== tb/tb.sv =====
// Testbench for exhaustive_tour_search: loads point sets, predicts the shortest closed tour
// and compares every result request. Depends on ets_pkg and the exhaustive_tour_search RTL.
`timescale 1ns / 100ps

module tb;

    localparam int NPTS = 8;
    localparam longint CYCLE_LIMIT = 64'd60000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    ets_pkg::in_req_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    ets_pkg::out_req_t m_data;
    logic cfg_we = 1'b0;
    logic [ets_pkg::LEN_W-1:0] cfg_data = '0;

    exhaustive_tour_search #(.MAX_POINTS(NPTS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // predictor state
    int pt_x[NPTS];
    int pt_y[NPTS];
    int loaded = 0;
    logic [ets_pkg::LEN_W-1:0] tour_limit = ets_pkg::LIMIT_RESET;

    ets_pkg::in_req_t point_queue[$];
    ets_pkg::out_req_t tour_queue[$];
    int errors = 0;
    int results_seen = 0;
    int sets_done = 0;
    int found_sets = 0;
    int limits_set = 0;
    longint cycles = 0;
    int send_gap = 0;
    int recv_gap = 0;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bits;
        res = 0;
        bits = 64'd1 << 62;
        while (bits > v) bits >>= 2;
        while (bits != 0) begin
            if (v >= res + bits) begin
                v = v - (res + bits);
                res = (res >> 1) + bits;
            end else begin
                res = res >> 1;
            end
            bits >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned edge_length(int a, int b);
        longint dx, dy;
        dx = longint'(pt_x[b]) - longint'(pt_x[a]);
        dy = longint'(pt_y[b]) - longint'(pt_y[a]);
        return int_sqrt(longint'(dx * dx + dy * dy));
    endfunction

    function automatic bit next_perm(ref int ord[NPTS], input int n);
        int i, j, t;
        if (n < 2) return 1'b0;
        i = n - 1;
        while (i > 0 && ord[i-1] >= ord[i]) i--;
        if (i == 0) return 1'b0;
        j = n - 1;
        while (ord[j] <= ord[i-1]) j--;
        t = ord[i-1]; ord[i-1] = ord[j]; ord[j] = t;
        j = n - 1;
        while (i < j) begin
            t = ord[i]; ord[i] = ord[j]; ord[j] = t;
            i++; j--;
        end
        return 1'b1;
    endfunction

    // Accepted request: store the point; a flagged one runs the whole search.
    task automatic predict_tour(input ets_pkg::in_req_t r);
        int ord[NPTS];
        int best_ord[NPTS];
        longint unsigned len, best;
        bit found;
        int n;
        ets_pkg::out_req_t o;
        if (loaded < NPTS) begin
            pt_x[loaded] = int'(r.point_x);
            pt_y[loaded] = int'(r.point_y);
            loaded++;
        end
        if (!r.last_point) return;
        n = loaded;
        best = tour_limit;
        found = 1'b0;
        for (int k = 0; k < NPTS; k++) begin
            ord[k] = k;
            best_ord[k] = 0;
        end
        do begin
            len = 0;
            for (int i = 0; i < n; i++) begin
                len += edge_length(ord[i], ord[(i + 1) % n]);
                if (len > ets_pkg::LEN_MAX) len = ets_pkg::LEN_MAX;
            end
            if (len < best) begin
                best = len;
                best_ord = ord;
                found = 1'b1;
            end
        end while (next_perm(ord, n));
        if (!found) begin
            o = '0;
            o.last_result = 1'b1;
            tour_queue = {tour_queue, o};
        end else begin
            found_sets++;
            for (int k = 0; k <= n; k++) begin
                o.tour_index = best_ord[k % n][ets_pkg::IDX_W-1:0];
                o.tour_length = best[ets_pkg::LEN_W-1:0];
                o.found = 1'b1;
                o.last_result = (k == n);
                tour_queue = {tour_queue, o};
            end
        end
        sets_done++;
        loaded = 0;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d, want %0d (result %0d)", what, got, want, results_seen);
        errors++;
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) predict_tour(s_data);
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 1'b0;
                end else if (point_queue.size() > 0) begin
                    s_valid <= 1'b1;
                    s_data <= point_queue.pop_front();
                    send_gap <= pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        ets_pkg::out_req_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** exhaustive_tour_search: FAILED **");
            $finish;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (tour_queue.size() == 0) begin
                    report_mismatch("unexpected request", 1, 0);
                end else begin
                    want = tour_queue.pop_front();
                    if (m_data.tour_index != want.tour_index)
                        report_mismatch("tour_index", m_data.tour_index, want.tour_index);
                    if (m_data.tour_length != want.tour_length)
                        report_mismatch("tour_length", m_data.tour_length, want.tour_length);
                    if (m_data.found != want.found)
                        report_mismatch("found", m_data.found, want.found);
                    if (m_data.last_result != want.last_result)
                        report_mismatch("last_result", m_data.last_result, want.last_result);
                end
                results_seen++;
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) recv_gap <= pick_gap();
            end
        end
    end

    task automatic add_point(input int x, input int y, input bit last);
        ets_pkg::in_req_t r;
        r.point_x = x[15:0];
        r.point_y = y[15:0];
        r.last_point = last;
        point_queue = {point_queue, r};
    endtask

    // mode 0: full range, 1: small cluster, 2: corners of the range
    task automatic add_set(input int n, input int mode);
        int x, y;
        for (int i = 0; i < n; i++) begin
            case (mode)
                0: begin
                    x = $urandom_range(0, 65535) - 32768;
                    y = $urandom_range(0, 65535) - 32768;
                end
                1: begin
                    x = $urandom_range(0, 2047) - 1024;
                    y = $urandom_range(0, 2047) - 1024;
                end
                default: begin
                    x = $urandom_range(0, 1) ? 32767 : -32768;
                    y = $urandom_range(0, 1) ? 32767 : -32768;
                end
            endcase
            add_point(x, y, i == n - 1);
        end
    endtask

    // waits until the block is idle, then writes the limit
    task automatic drain_and_config(input logic [ets_pkg::LEN_W-1:0] v);
        while (point_queue.size() > 0 || s_valid || tour_queue.size() > 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        tour_limit = v;
        limits_set++;
    endtask

    initial begin
        int items;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, reset limit
        add_point(-32768, 32767, 1'b1);             // single point
        add_point(-32768, -32768, 1'b0);
        add_point(32767, 32767, 1'b1);              // diagonal extremes
        add_set(3, 2);
        for (int i = 0; i < 4; i++) add_point(100, -100, i == 3);   // all coincident
        drain_and_config(ets_pkg::LEN_MAX);
        // overflow: nine points, the flagged ninth is not stored but still starts the search
        for (int i = 0; i < 9; i++) add_point(i * 37 - 150, (i * 91) % 200 - 100, i == 8);
        add_set(4, 0);
        drain_and_config('0);                       // nothing can beat zero
        add_set(1, 1);
        add_set(3, 0);
        drain_and_config(20'd300);                  // tight limit, mixed outcomes
        add_set(3, 1);
        add_set(2, 1);

        items = 0;
        while (items < 140) begin
            drain_and_config(20'($urandom_range(0, 7) == 0 ? $urandom_range(0, 2000)
                                                           : $urandom_range(0, ets_pkg::LEN_MAX)));
            for (int s = 0; s < 8; s++) begin
                int n;
                n = ($urandom_range(0, 19) == 0) ? 6 : $urandom_range(1, 5);
                add_set(n, $urandom_range(0, 4) == 0 ? 2 : $urandom_range(0, 1));
                items += n;
            end
        end
        drain_and_config(ets_pkg::LIMIT_RESET);
        add_set(5, 0);

        while (point_queue.size() > 0 || s_valid || tour_queue.size() > 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("covered %0d point sets (%0d with a tour under the limit), %0d results,",
                 sets_done, found_sets, results_seen);
        $display("%0d limit writes including zero and full scale", limits_set);
        if (errors == 0 && tour_queue.size() == 0) begin
            $display("** exhaustive_tour_search: PASSED **");
        end else begin
            $display("** exhaustive_tour_search: FAILED **");
        end
        $finish;
    end

endmodule
